// ===== rtl/ambs_pkg.sv =====
// Shared types and constants for the annulus median background subtractor.
package ambs_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 27;
	localparam int CFG_DIM_W  = 13;
	localparam int CFG_RAD_W  = 27;
	localparam int SPREAD_W   = 32;
	localparam int QUO_W      = 64;
	localparam int FRAC_SHIFT = 16;

	localparam logic [CFG_DIM_W-1:0] RST_HEIGHT = 13'd64;
	localparam logic [CFG_DIM_W-1:0] RST_WIDTH  = 13'd64;
	localparam logic [CFG_RAD_W-1:0] RST_INNER  = 27'd0;
	localparam logic [CFG_RAD_W-1:0] RST_OUTER  = 27'd4096;

	localparam logic [QUO_W-1:0] SQRT_BIT0 = 64'h4000_0000_0000_0000;

	localparam logic OP_GATHER   = 1'b0;
	localparam logic OP_SUBTRACT = 1'b1;
	localparam logic KIND_STATS  = 1'b0;
	localparam logic KIND_PIXEL  = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_HEIGHT = 3'd0,
		REG_IMAGE_WIDTH  = 3'd1,
		REG_INNER_SQ4    = 3'd2,
		REG_OUTER_SQ4    = 3'd3,
		REG_USE_STD_ERR  = 3'd4
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_G_MUL,
		ST_G_UPD,
		ST_FIN,
		ST_SEL_SCAN,
		ST_SEL_STEP,
		ST_MUL,
		ST_DIV,
		ST_SQRT,
		ST_EMIT_STAT,
		ST_EMIT_SUB
	} state_t;

	typedef enum logic [1:0] {
		MS_T1,
		MS_T2,
		MS_DEN1,
		MS_DEN2
	} mul_sel_t;

endpackage

// ===== rtl/ambs_ram.sv =====
// Generic single write port RAM with registered read.
module ambs_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/annulus_median_background_subtract.sv =====
// Annulus median background subtractor: slice statistics and pixel subtraction.
//
//  channel | dir | handshake            | word
//  in      | in  | in_valid / in_stall   | operation, pixel_value, pixel_finite
//  out     | out | out_valid / out_stall | result_kind .. pixel_out_valid
//  cfg     | in  | cfg_write_en          | cfg_index, cfg_data
//
// Gather word: coordinate and pixel squares, then accumulate and store.
// Subtract word: accepted, then held until the output register is free.
// Slice end: 2 median passes of PIXEL_BITS sweeps, each over the
// sample RAM read port, then shift-add multiplies, restoring division
// and square root, all on one sequenced unit each.
// No clearing pass after reset; the sample RAM is only read below the fill count.
module annulus_median_background_subtract #(
	parameter int MAX_SAMPLES = 4096,
	parameter int MAX_DIM     = 4096,
	parameter int PIXEL_BITS  = 24
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  operation,
	input  logic signed [PIXEL_BITS-1:0]          pixel_value,
	input  logic                                  pixel_finite,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic                                  result_kind,
	output logic signed [PIXEL_BITS:0]            background_half,
	output logic                                  background_valid,
	output logic [ambs_pkg::SPREAD_W-1:0]         spread_fixed,
	output logic                                  spread_valid,
	output logic [$clog2(MAX_SAMPLES+1)-1:0]      finite_count,
	output logic [2*$clog2(MAX_DIM):0]            mask_count,
	output logic                                  store_overflow,
	output logic signed [PIXEL_BITS+1:0]          pixel_out_half,
	output logic                                  pixel_out_valid,
	input  logic                                  cfg_write_en,
	input  logic [ambs_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [ambs_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import ambs_pkg::*;

	localparam int PB   = PIXEL_BITS;
	localparam int NW   = $clog2(MAX_SAMPLES + 1);
	localparam int AW   = $clog2(MAX_SAMPLES);
	localparam int DW   = $clog2(MAX_DIM);
	localparam int EW   = DW + 1;
	localparam int DXW  = DW + 3;
	localparam int SQDW = 2 * DW + 2;
	localparam int DSW  = 2 * DW + 3;
	localparam int CMPW = (DSW > CFG_RAD_W) ? DSW : CFG_RAD_W;
	localparam int MCW  = 2 * DW + 1;
	localparam int SUMW = PB + NW;
	localparam int SQW  = 2 * PB + NW;
	localparam int NUMW = SQW + NW;
	localparam int DENW = 3 * NW;
	localparam int DVDW = NUMW + FRAC_SHIFT;
	localparam int DCW  = $clog2(DVDW + 1);
	localparam int BW   = $clog2(PB);

	state_t state_q, state_d;

	// configuration
	logic [CFG_DIM_W-1:0] cfg_h_q, cfg_w_q;
	logic [CFG_RAD_W-1:0] cfg_in_q, cfg_out_q;
	logic                 cfg_se_q;

	// slice state
	logic [NW-1:0]          count_q;
	logic signed [SUMW-1:0] sum_q;
	logic [SQW-1:0]         sumsq_q;
	logic [DW-1:0]          row_q, col_q;
	logic [MCW-1:0]         annulus_q;
	logic                   ovf_q;
	logic signed [PB:0]     held_bg_q;
	logic                   held_valid_q;

	// latched input word and gather products
	logic                 fin_q;
	logic signed [PB-1:0] pix_q;
	logic [SQDW-1:0]      dx2_q, dy2_q;
	logic [2*PB-1:0]      mag2_q;

	// median select
	logic [NW-1:0]        addr_q, cnt_q, k_q;
	logic                 rdv_q, pass_q;
	logic [PB-1:0]        prefix_q;
	logic [BW-1:0]        sel_bit_q;
	logic signed [PB-1:0] med_a_q;

	// shared shift-add multiplier
	logic [NUMW-1:0] mul_a_q, acc_q, num_q;
	logic [SUMW-1:0] mul_b_q;
	mul_sel_t        mul_sel_q;
	logic [DENW-1:0] den_q;

	// divider and root
	logic [DVDW-1:0]     dvd_q;
	logic [DENW-1:0]     rem_q;
	logic [QUO_W-1:0]    quo_q;
	logic                sat_q;
	logic [DCW-1:0]      dcnt_q;
	logic [QUO_W-1:0]    sx_q, sr_q, sb_q;
	logic [SPREAD_W-1:0] spread_q;

	// output register
	logic                 out_valid_q, kind_q, bgv_q, spv_q, ovfo_q, pv_q;
	logic signed [PB:0]   bg_o_q;
	logic [SPREAD_W-1:0]  spread_o_q;
	logic [NW-1:0]        fc_q;
	logic [MCW-1:0]       mc_q;
	logic signed [PB+1:0] po_q;

	// RAM
	logic          ram_we;
	logic [PB-1:0] ram_rdata;

	// ---------------- combinational datapath ----------------
	logic [EW-1:0] h_eff, w_eff, row_inc, col_inc;
	assign h_eff = (cfg_h_q == '0) ? EW'(1) :
		((32'(cfg_h_q) > 32'(MAX_DIM)) ? EW'(MAX_DIM) : EW'(cfg_h_q));
	assign w_eff = (cfg_w_q == '0) ? EW'(1) :
		((32'(cfg_w_q) > 32'(MAX_DIM)) ? EW'(MAX_DIM) : EW'(cfg_w_q));
	assign row_inc = {1'b0, row_q} + EW'(1);
	assign col_inc = {1'b0, col_q} + EW'(1);

	logic signed [DXW-1:0]   dx_c, dy_c;
	logic signed [2*DXW-1:0] dxsq_c, dysq_c;
	logic [PB-1:0]           pix_u, mag_c;
	assign dx_c   = $signed({2'b00, col_q, 1'b1}) - $signed({2'b00, w_eff});
	assign dy_c   = $signed({2'b00, row_q, 1'b1}) - $signed({2'b00, h_eff});
	assign dxsq_c = dx_c * dx_c;
	assign dysq_c = dy_c * dy_c;
	assign pix_u  = pix_q;
	assign mag_c  = pix_u[PB-1] ? (~pix_u + PB'(1)) : pix_u;

	logic [DSW-1:0] d_c;
	logic           in_ann_c, store_c, last_c;
	assign d_c      = DSW'(dx2_q) + DSW'(dy2_q);
	assign in_ann_c = (CMPW'(d_c) >= CMPW'(cfg_in_q)) && (CMPW'(d_c) <= CMPW'(cfg_out_q));
	assign store_c  = in_ann_c && fin_q && (count_q < NW'(MAX_SAMPLES));
	assign last_c   = !(row_inc < h_eff) && !(col_inc < w_eff);

	// bitwise k-th smallest: compare in offset binary
	logic [PB-1:0]        u_c, bit_oh, cmp_mask, next_prefix;
	logic                 match_c, take1_c;
	logic signed [PB-1:0] sel_val_c;
	assign u_c         = {~ram_rdata[PB-1], ram_rdata[PB-2:0]};
	assign bit_oh      = PB'(1) << sel_bit_q;
	assign cmp_mask    = ~((bit_oh << 1) - PB'(1)) | bit_oh;
	assign match_c     = ((u_c ^ prefix_q) & cmp_mask) == '0;
	assign take1_c     = (k_q >= cnt_q);
	assign next_prefix = take1_c ? (prefix_q | bit_oh) : prefix_q;
	assign sel_val_c   = $signed({~next_prefix[PB-1], next_prefix[PB-2:0]});

	logic [SUMW-1:0] sum_u, smag_c;
	logic            mul_done_c, go_div_c;
	assign sum_u      = sum_q;
	assign smag_c     = sum_u[SUMW-1] ? (~sum_u + SUMW'(1)) : sum_u;
	assign mul_done_c = (mul_b_q == '0);
	assign go_div_c   = mul_done_c && ((mul_sel_q == MS_DEN2) ||
		((mul_sel_q == MS_DEN1) && !cfg_se_q));

	logic [DENW:0]    rem_sh, rem_sub;
	logic             div_ge;
	logic [QUO_W-1:0] sq_trial;
	logic             sq_ge;
	assign rem_sh   = {rem_q, dvd_q[DVDW-1]};
	assign div_ge   = rem_sh >= {1'b0, den_q};
	assign rem_sub  = rem_sh - {1'b0, den_q};
	assign sq_trial = sr_q + sb_q;
	assign sq_ge    = sx_q >= sq_trial;

	logic out_free_c, out_load_c;
	assign out_free_c = !out_valid_q || !out_stall;

	// ---------------- sequencer ----------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (operation == OP_SUBTRACT) ? ST_EMIT_SUB : ST_G_MUL;
				end
			end
			ST_G_MUL: state_d = ST_G_UPD;
			ST_G_UPD: state_d = last_c ? ST_FIN : ST_IDLE;
			ST_FIN: state_d = (count_q == '0) ? ST_EMIT_STAT : ST_SEL_SCAN;
			ST_SEL_SCAN: begin
				if (addr_q == count_q && !rdv_q) begin
					state_d = ST_SEL_STEP;
				end
			end
			ST_SEL_STEP: begin
				if (sel_bit_q == '0 && pass_q) begin
					state_d = (count_q >= NW'(2)) ? ST_MUL : ST_EMIT_STAT;
				end else begin
					state_d = ST_SEL_SCAN;
				end
			end
			ST_MUL: if (go_div_c) state_d = ST_DIV;
			ST_DIV: if (dcnt_q == '0) state_d = ST_SQRT;
			ST_SQRT: if (sb_q == '0) state_d = ST_EMIT_STAT;
			ST_EMIT_STAT, ST_EMIT_SUB: if (out_free_c) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall   = (state_q != ST_IDLE);
		ram_we     = (state_q == ST_G_UPD) && store_c;
		out_load_c = ((state_q == ST_EMIT_STAT) || (state_q == ST_EMIT_SUB)) && out_free_c;
	end

	// ---------------- control and slice state ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cfg_h_q      <= RST_HEIGHT;
			cfg_w_q      <= RST_WIDTH;
			cfg_in_q     <= RST_INNER;
			cfg_out_q    <= RST_OUTER;
			cfg_se_q     <= 1'b0;
			count_q      <= '0;
			sum_q        <= '0;
			sumsq_q      <= '0;
			row_q        <= '0;
			col_q        <= '0;
			annulus_q    <= '0;
			ovf_q        <= 1'b0;
			held_bg_q    <= '0;
			held_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_write_en) begin
				case (cfg_index)
					REG_IMAGE_HEIGHT: cfg_h_q   <= cfg_data[CFG_DIM_W-1:0];
					REG_IMAGE_WIDTH:  cfg_w_q   <= cfg_data[CFG_DIM_W-1:0];
					REG_INNER_SQ4:    cfg_in_q  <= cfg_data[CFG_RAD_W-1:0];
					REG_OUTER_SQ4:    cfg_out_q <= cfg_data[CFG_RAD_W-1:0];
					REG_USE_STD_ERR:  cfg_se_q  <= cfg_data[0];
					default: ;
				endcase
			end
			if (state_q == ST_G_UPD) begin
				if (in_ann_c) begin
					if (annulus_q != '1) annulus_q <= annulus_q + MCW'(1);
					if (fin_q) begin
						if (store_c) begin
							count_q <= count_q + NW'(1);
							sum_q   <= sum_q + SUMW'(pix_q);
							sumsq_q <= sumsq_q + SQW'(mag2_q);
						end else begin
							ovf_q <= 1'b1;
						end
					end
				end
				if (row_inc < h_eff) begin
					row_q <= row_inc[DW-1:0];
				end else begin
					row_q <= '0;
					if (col_inc < w_eff) col_q <= col_inc[DW-1:0];
				end
			end
			if (state_q == ST_FIN) begin
				held_bg_q    <= '0;
				held_valid_q <= 1'b0;
			end
			if (state_q == ST_SEL_STEP && sel_bit_q == '0 && pass_q) begin
				held_bg_q    <= $signed({med_a_q[PB-1], med_a_q}) +
					$signed({sel_val_c[PB-1], sel_val_c});
				held_valid_q <= 1'b1;
			end
			if (out_load_c && state_q == ST_EMIT_STAT) begin
				count_q   <= '0;
				sum_q     <= '0;
				sumsq_q   <= '0;
				row_q     <= '0;
				col_q     <= '0;
				annulus_q <= '0;
				ovf_q     <= 1'b0;
			end
			if (out_load_c) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ---------------- working registers ----------------
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				pix_q <= pixel_value;
				fin_q <= pixel_finite;
			end
			ST_G_MUL: begin
				dx2_q  <= dxsq_c[SQDW-1:0];
				dy2_q  <= dysq_c[SQDW-1:0];
				mag2_q <= mag_c * mag_c;
			end
			ST_FIN: begin
				addr_q    <= '0;
				rdv_q     <= 1'b0;
				cnt_q     <= '0;
				prefix_q  <= '0;
				sel_bit_q <= BW'(PB - 1);
				pass_q    <= 1'b0;
				k_q       <= (count_q - NW'(1)) >> 1;
			end
			ST_SEL_SCAN: begin
				if (addr_q < count_q) addr_q <= addr_q + NW'(1);
				rdv_q <= (addr_q < count_q);
				if (rdv_q && match_c) cnt_q <= cnt_q + NW'(1);
			end
			ST_SEL_STEP: begin
				addr_q <= '0;
				rdv_q  <= 1'b0;
				cnt_q  <= '0;
				if (sel_bit_q == '0) begin
					prefix_q  <= '0;
					sel_bit_q <= BW'(PB - 1);
					if (!pass_q) begin
						med_a_q <= sel_val_c;
						pass_q  <= 1'b1;
						k_q     <= count_q >> 1;
					end else begin
						mul_a_q   <= NUMW'(sumsq_q);
						mul_b_q   <= SUMW'(count_q);
						acc_q     <= '0;
						mul_sel_q <= MS_T1;
					end
				end else begin
					prefix_q  <= next_prefix;
					sel_bit_q <= sel_bit_q - BW'(1);
					if (take1_c) k_q <= k_q - cnt_q;
				end
			end
			ST_MUL: begin
				if (!mul_done_c) begin
					if (mul_b_q[0]) acc_q <= acc_q + mul_a_q;
					mul_a_q <= mul_a_q << 1;
					mul_b_q <= mul_b_q >> 1;
				end else begin
					acc_q <= '0;
					case (mul_sel_q)
						MS_T1: begin
							num_q     <= acc_q;
							mul_a_q   <= NUMW'(smag_c);
							mul_b_q   <= smag_c;
							mul_sel_q <= MS_T2;
						end
						MS_T2: begin
							num_q     <= num_q - acc_q;
							mul_a_q   <= NUMW'(count_q);
							mul_b_q   <= SUMW'(count_q - NW'(1));
							mul_sel_q <= MS_DEN1;
						end
						MS_DEN1: begin
							den_q     <= acc_q[DENW-1:0];
							mul_a_q   <= acc_q;
							mul_b_q   <= SUMW'(count_q - NW'(1));
							mul_sel_q <= MS_DEN2;
						end
						MS_DEN2: den_q <= acc_q[DENW-1:0];
						default: ;
					endcase
					if (go_div_c) begin
						dvd_q  <= {num_q, {FRAC_SHIFT{1'b0}}};
						rem_q  <= '0;
						quo_q  <= '0;
						sat_q  <= 1'b0;
						dcnt_q <= DCW'(DVDW);
					end
				end
			end
			ST_DIV: begin
				if (dcnt_q != '0) begin
					dvd_q  <= dvd_q << 1;
					rem_q  <= div_ge ? rem_sub[DENW-1:0] : rem_sh[DENW-1:0];
					quo_q  <= {quo_q[QUO_W-2:0], div_ge};
					sat_q  <= sat_q | quo_q[QUO_W-1];
					dcnt_q <= dcnt_q - DCW'(1);
				end else begin
					sx_q <= sat_q ? '1 : quo_q;
					sr_q <= '0;
					sb_q <= SQRT_BIT0;
				end
			end
			ST_SQRT: begin
				if (sb_q != '0) begin
					if (sq_ge) begin
						sx_q <= sx_q - sq_trial;
						sr_q <= (sr_q >> 1) + sb_q;
					end else begin
						sr_q <= sr_q >> 1;
					end
					sb_q <= sb_q >> 2;
				end else begin
					spread_q <= sr_q[SPREAD_W-1:0];
				end
			end
			default: ;
		endcase

		if (out_load_c) begin
			bg_o_q <= held_bg_q;
			bgv_q  <= held_valid_q;
			if (state_q == ST_EMIT_STAT) begin
				kind_q     <= KIND_STATS;
				spv_q      <= (count_q >= NW'(2));
				spread_o_q <= (count_q >= NW'(2)) ? spread_q : '0;
				fc_q       <= count_q;
				mc_q       <= annulus_q;
				ovfo_q     <= ovf_q;
				po_q       <= '0;
				pv_q       <= 1'b0;
			end else begin
				kind_q     <= KIND_PIXEL;
				spv_q      <= 1'b0;
				spread_o_q <= '0;
				fc_q       <= '0;
				mc_q       <= '0;
				ovfo_q     <= 1'b0;
				pv_q       <= fin_q && held_valid_q;
				po_q       <= (fin_q && held_valid_q) ?
					($signed({pix_q[PB-1], pix_q, 1'b0}) - $signed({held_bg_q[PB], held_bg_q})) :
					'0;
			end
		end
	end

	ambs_ram #(
		.WIDTH(PB),
		.DEPTH(MAX_SAMPLES)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q[AW-1:0]),
		.wdata(pix_u),
		.raddr(addr_q[AW-1:0]),
		.rdata(ram_rdata)
	);

	assign out_valid        = out_valid_q;
	assign result_kind      = kind_q;
	assign background_half  = bg_o_q;
	assign background_valid = bgv_q;
	assign spread_fixed     = spread_o_q;
	assign spread_valid     = spv_q;
	assign finite_count     = fc_q;
	assign mask_count       = mc_q;
	assign store_overflow   = ovfo_q;
	assign pixel_out_half   = po_q;
	assign pixel_out_valid  = pv_q;

endmodule

// ===== rtl/ambs_checker.sv =====
// Port-level checks for the annulus median background subtractor, bound to the top level.
module ambs_checker #(
	parameter int MAX_SAMPLES = 4096,
	parameter int MAX_DIM     = 4096,
	parameter int PIXEL_BITS  = 24
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_stall,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic                             result_kind,
	input logic signed [PIXEL_BITS:0]       background_half,
	input logic                             background_valid,
	input logic [ambs_pkg::SPREAD_W-1:0]    spread_fixed,
	input logic                             spread_valid,
	input logic [$clog2(MAX_SAMPLES+1)-1:0] finite_count,
	input logic [2*$clog2(MAX_DIM):0]       mask_count,
	input logic                             store_overflow,
	input logic signed [PIXEL_BITS+1:0]     pixel_out_half,
	input logic                             pixel_out_valid
);
	import ambs_pkg::*;

	// a held result word keeps its contents
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result_kind) &&
		$stable(background_half) && $stable(pixel_out_half))
		else $error("result word changed while stalled");

	// the block is busy after every accepted word, so an accept is followed by a stall
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted on consecutive cycles");

	a_pixel_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_PIXEL |-> spread_fixed == '0 && !spread_valid &&
		finite_count == '0 && mask_count == '0 && !store_overflow)
		else $error("statistics fields set on a subtract result");

	a_no_bg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !background_valid |-> background_half == '0 && !pixel_out_valid)
		else $error("invalid background carries data");

	a_stats: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_STATS |-> pixel_out_half == '0 && !pixel_out_valid &&
		(spread_valid || spread_fixed == '0) && (!spread_valid || background_valid) &&
		(background_valid || finite_count == '0))
		else $error("inconsistent statistics result");

endmodule

bind annulus_median_background_subtract ambs_checker #(
	.MAX_SAMPLES(MAX_SAMPLES),
	.MAX_DIM    (MAX_DIM),
	.PIXEL_BITS (PIXEL_BITS)
) u_ambs_checker (.*);
